// File: rtl/core/dbd_pkg.sv
// Shared types, constants and helpers of the depth block downscaler.
`timescale 1ns / 1ps

package dbd_pkg;

    // Fixed field widths
    localparam int DEPTH_W   = 16;
    localparam int SUM_W     = 22;
    localparam int CNT_W     = 7;
    localparam int STEP_W    = 4;
    localparam int DIM_W     = 11;
    localparam int MAX_COLS  = 1024;
    localparam int MAX_STEP  = 8;
    localparam int MAX_ROWS  = 1024;
    localparam int COL_IDX_W = $clog2(MAX_COLS);
    localparam int POS_W     = 10;
    localparam int IN_BLK_W  = 3;
    localparam int EDGE_W    = 12;
    localparam int ENTRY_W   = SUM_W + CNT_W;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Request queue between front and back end
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_STEP = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_ROWS = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RESET = 4'd2;
    localparam logic [DIM_W-1:0]  COLS_RESET = 11'd640;
    localparam logic [DIM_W-1:0]  ROWS_RESET = 11'd480;

    // Effective (clamped) geometry
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [DIM_W-1:0]  cols;
        logic [DIM_W-1:0]  rows;
    } cfg_t;

    // Classified pixel request passed from front to back
    typedef struct packed {
        logic [DEPTH_W-1:0]   depth;
        logic [COL_IDX_W-1:0] col;
        logic                 first;
        logic                 last;
        logic                 row_end;
        logic                 frame_end;
    } cmd_t;

    function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] r;
        if (s == '0)
            r = STEP_W'(1);
        else if (s > STEP_W'(MAX_STEP))
            r = STEP_W'(MAX_STEP);
        else
            r = s;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

// File: rtl/core/depth_block_downscale.sv
// Top level of the depth block downscaler: configuration registers and wiring.
`timescale 1ns / 1ps

// Block-average downscaler for 16-bit depth images; zero pixels are ignored.
// Input: push a pixel in raster order when full is low. Output: while empty
// is low, depth_avg/row_end/frame_end hold the oldest result; pop takes it.
// One result leaves for each whole block_step x block_step block, at its
// bottom-right pixel; rows and columns past the last whole block are dropped.
// The back end takes each pixel inside a block by a memory read, then an add
// and write back; on a block's last pixel it then runs the 22-step serial
// divide and loads the result register (a block with no valid pixel skips the
// divide). Pixels outside whole blocks are dropped by the front end. The back
// end takes no new request until it is through with the last; a four-request
// queue lets the front end run ahead while the back end divides.
// If the receiver stalls, the result register holds, the back end waits,
// the queue fills and full rises. Reset sets block_step 2, image 640 x 480
// and restarts the frame; the column memory needs no clearing since each
// entry is written by the first pixel of its block. Any register write
// restarts the frame; write registers only while the block is idle.

module depth_block_downscale (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [15:0] depth,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] depth_avg,
    output logic        row_end,
    output logic        frame_end
);
    import dbd_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIM_W-1:0]  cols_reg, cols_next;
    logic [DIM_W-1:0]  rows_reg, rows_next;
    logic              wr_en;
    logic              restart;
    cfg_t              cfg;
    logic              q_push, q_full, q_pop, q_empty;
    cmd_t              q_data, q_head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Decode the register write; a write past the last register is dropped
    always_comb
    begin
        step_next = step_reg;
        cols_next = cols_reg;
        rows_next = rows_reg;
        restart   = 1'b0;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_STEP:
                begin
                    step_next = pwdata[STEP_W-1:0];
                    restart   = 1'b1;
                end
                REG_COLS:
                begin
                    cols_next = pwdata[DIM_W-1:0];
                    restart   = 1'b1;
                end
                REG_ROWS:
                begin
                    rows_next = pwdata[DIM_W-1:0];
                    restart   = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Register readback returns the raw written values
    always_comb
    begin
        case (paddr[3:2])
            REG_STEP: prdata = PDATA_W'(step_reg);
            REG_COLS: prdata = PDATA_W'(cols_reg);
            REG_ROWS: prdata = PDATA_W'(rows_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end
        else
        begin
            step_reg <= step_next;
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    // Out-of-range settings act as the nearest legal value
    always_comb
    begin
        cfg.step = clamp_step(step_reg);
        cfg.cols = clamp_dim(cols_reg, DIM_W'(MAX_COLS));
        cfg.rows = clamp_dim(rows_reg, DIM_W'(MAX_ROWS));
    end

    dbd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (restart),
        .push    (push),
        .full    (full),
        .depth   (depth),
        .q_push  (q_push),
        .q_data  (q_data),
        .q_full  (q_full)
    );

    dbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop_en    (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    dbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .depth_avg (depth_avg),
        .row_end   (row_end),
        .frame_end (frame_end),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// File: rtl/core/dbd_front.sv
// Front end: tracks the raster position and classifies each pixel request.
`timescale 1ns / 1ps

module dbd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  dbd_pkg::cfg_t cfg,
    input  logic          restart,
    input  logic          push,
    output logic          full,
    input  logic [15:0]   depth,
    output logic          q_push,
    output dbd_pkg::cmd_t q_data,
    input  logic          q_full
);
    import dbd_pkg::*;

    logic [POS_W-1:0]     pcol_reg, pcol_next;
    logic [POS_W-1:0]     prow_reg, prow_next;
    logic [IN_BLK_W-1:0]  cib_reg, cib_next;
    logic [IN_BLK_W-1:0]  rib_reg, rib_next;
    logic [COL_IDX_W-1:0] bcol_reg, bcol_next;
    logic [DIM_W-1:0]     cstart_reg, cstart_next;
    logic [DIM_W-1:0]     rstart_reg, rstart_next;

    logic [EDGE_W-1:0] col_end, row_end_pos;
    logic [STEP_W-1:0] cib_inc, rib_inc, step_m1;
    logic [DIM_W-1:0]  pcol_inc, prow_inc;
    logic              in_col, in_row, accept;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign step_m1 = cfg.step - STEP_W'(1);

    assign col_end     = EDGE_W'(cstart_reg) + EDGE_W'(cfg.step);
    assign row_end_pos = EDGE_W'(rstart_reg) + EDGE_W'(cfg.step);
    assign in_col      = col_end <= EDGE_W'(cfg.cols);
    assign in_row      = row_end_pos <= EDGE_W'(cfg.rows);

    always_comb
    begin
        q_data.depth     = depth;
        q_data.col       = bcol_reg;
        q_data.first     = (cib_reg == '0) && (rib_reg == '0);
        q_data.last      = (STEP_W'(cib_reg) == step_m1) && (STEP_W'(rib_reg) == step_m1);
        q_data.row_end   = (col_end + EDGE_W'(cfg.step)) > EDGE_W'(cfg.cols);
        q_data.frame_end = q_data.row_end
                           && ((row_end_pos + EDGE_W'(cfg.step)) > EDGE_W'(cfg.rows));
    end

    assign q_push = accept && in_col && in_row;

    assign cib_inc  = STEP_W'(cib_reg) + STEP_W'(1);
    assign rib_inc  = STEP_W'(rib_reg) + STEP_W'(1);
    assign pcol_inc = DIM_W'(pcol_reg) + DIM_W'(1);
    assign prow_inc = DIM_W'(prow_reg) + DIM_W'(1);

    always_comb
    begin
        pcol_next   = pcol_reg;
        prow_next   = prow_reg;
        cib_next    = cib_reg;
        rib_next    = rib_reg;
        bcol_next   = bcol_reg;
        cstart_next = cstart_reg;
        rstart_next = rstart_reg;
        if (restart)
        begin
            pcol_next   = '0;
            prow_next   = '0;
            cib_next    = '0;
            rib_next    = '0;
            bcol_next   = '0;
            cstart_next = '0;
            rstart_next = '0;
        end
        else if (accept)
        begin
            // advance inside the block row
            if (cib_inc >= cfg.step)
            begin
                cib_next    = '0;
                bcol_next   = bcol_reg + COL_IDX_W'(1);
                cstart_next = cstart_reg + DIM_W'(cfg.step);
            end
            else
            begin
                cib_next = cib_inc[IN_BLK_W-1:0];
            end
            pcol_next = pcol_inc[POS_W-1:0];
            // end of source row
            if (pcol_inc >= cfg.cols)
            begin
                pcol_next   = '0;
                cib_next    = '0;
                bcol_next   = '0;
                cstart_next = '0;
                prow_next   = prow_inc[POS_W-1:0];
                if (rib_inc >= cfg.step)
                begin
                    rib_next    = '0;
                    rstart_next = rstart_reg + DIM_W'(cfg.step);
                end
                else
                begin
                    rib_next = rib_inc[IN_BLK_W-1:0];
                end
                if (prow_inc >= cfg.rows)
                begin
                    prow_next   = '0;
                    rib_next    = '0;
                    rstart_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcol_reg   <= '0;
            prow_reg   <= '0;
            cib_reg    <= '0;
            rib_reg    <= '0;
            bcol_reg   <= '0;
            cstart_reg <= '0;
            rstart_reg <= '0;
        end
        else
        begin
            pcol_reg   <= pcol_next;
            prow_reg   <= prow_next;
            cib_reg    <= cib_next;
            rib_reg    <= rib_next;
            bcol_reg   <= bcol_next;
            cstart_reg <= cstart_next;
            rstart_reg <= rstart_next;
        end
    end

endmodule

// File: rtl/core/dbd_queue.sv
// Four-entry request queue between the front end and the back end.
`timescale 1ns / 1ps

module dbd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_en,
    input  dbd_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop_en,
    output dbd_pkg::cmd_t head,
    output logic          empty
);
    import dbd_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   fill_reg, fill_next;

    assign full  = fill_reg == (Q_PTR_W+1)'(Q_DEPTH);
    assign empty = fill_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_en ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop_en ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_en && !pop_en)
            fill_next = fill_reg + (Q_PTR_W+1)'(1);
        else if (pop_en && !push_en)
            fill_next = fill_reg - (Q_PTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// File: rtl/core/dbd_back.sv
// Back end: per-column accumulation memory, serial divider and result register.
`timescale 1ns / 1ps

module dbd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  dbd_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic [15:0]   depth_avg,
    output logic          row_end,
    output logic          frame_end,
    output logic          empty,
    input  logic          pop
);
    import dbd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [ENTRY_W-1:0]   rd_reg;
    logic [ENTRY_W-1:0]   mem [MAX_COLS];
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     div_reg, div_next;
    logic [DIV_CNT_W-1:0] iter_reg, iter_next;
    logic [DEPTH_W-1:0]   res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DEPTH_W-1:0]   avg_reg, avg_next;
    logic                 re_reg, re_next;
    logic                 fe_reg, fe_next;

    logic [SUM_W-1:0]     acc_sum;
    logic [CNT_W-1:0]     acc_cnt;
    logic [CNT_W:0]       trial;
    logic                 fits;
    logic                 mem_we;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign empty     = !out_valid_reg;
    assign depth_avg = avg_reg;
    assign row_end   = re_reg;
    assign frame_end = fe_reg;

    // first pixel of a block restarts the column's running sum
    assign acc_sum = cmd_reg.first ? SUM_W'(cmd_reg.depth)
                   : rd_reg[ENTRY_W-1:CNT_W] + SUM_W'(cmd_reg.depth);
    assign acc_cnt = cmd_reg.first ? CNT_W'(cmd_reg.depth != '0)
                   : rd_reg[CNT_W-1:0] + CNT_W'(cmd_reg.depth != '0);
    assign mem_we  = state_reg == ST_ACC;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        iter_next      = iter_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !pop;
        avg_next       = avg_reg;
        re_next        = re_reg;
        fe_next        = fe_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!cmd_reg.last)
                    state_next = ST_IDLE;
                else if (acc_cnt == '0)
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    quo_next   = acc_sum;
                    div_next   = acc_cnt;
                    iter_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = fits ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], fits};
                iter_next = iter_reg + DIV_CNT_W'(1);
                if (iter_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    res_next   = quo_next[DEPTH_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    avg_next       = res_reg;
                    re_next        = cmd_reg.row_end;
                    fe_next        = cmd_reg.frame_end;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[cmd_reg.col] <= {acc_sum, acc_cnt};
        if (q_pop)
            rd_reg <= mem[q_head.col];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_head;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
        iter_reg <= iter_next;
        res_reg  <= res_next;
        avg_reg  <= avg_next;
        re_reg   <= re_next;
        fe_reg   <= fe_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
